FILE: hw/rtl/banked_interrupt_controller_assert.svh
// Assertion macros used by the interrupt controller RTL.
`ifndef BANKED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define BANKED_INTERRUPT_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bic_pkg.sv
// Shared constants, types and helper functions of the banked interrupt controller.
package bic_pkg;

    localparam int SOURCE_COUNT_DEFAULT = 72;
    localparam int BANK_WIDTH           = 32;
    localparam int BASIC_BASE           = 64;
    localparam int ACTIVE_WIDTH         = 7;
    localparam int OUT_TDATA_WIDTH      = 40;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;

    localparam logic [3:0] REG_PEND_BASIC = 4'd0;
    localparam logic [3:0] REG_PEND_BANK1 = 4'd1;
    localparam logic [3:0] REG_PEND_BANK2 = 4'd2;
    localparam logic [3:0] REG_FIQ_CTRL   = 4'd3;
    localparam logic [3:0] REG_EN_BANK1   = 4'd4;
    localparam logic [3:0] REG_EN_BANK2   = 4'd5;
    localparam logic [3:0] REG_EN_BASIC   = 4'd6;
    localparam logic [3:0] REG_DIS_BANK1  = 4'd7;
    localparam logic [3:0] REG_DIS_BANK2  = 4'd8;
    localparam logic [3:0] REG_DIS_BASIC  = 4'd9;

    // Bank selector placed above the bit index in active_source.
    localparam logic [1:0] BANK_SEL_1     = 2'd0;
    localparam logic [1:0] BANK_SEL_2     = 2'd1;
    localparam logic [1:0] BANK_SEL_BASIC = 2'd2;

    typedef logic [BANK_WIDTH-1:0] word_t;

    // Index of the lowest set bit, zero when no bit is set.
    function automatic logic [4:0] lowest_set(input word_t v);
        logic [4:0] r;
        r = '0;
        for (int i = BANK_WIDTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/banked_interrupt_controller.sv
// Banked interrupt controller: enable registers, pending logic and priority encoder.
//
// Each slave-side transaction carries a sample of all source levels and may
// also carry a register access (sample only, read, or write). Writing ones to
// an enable register sets enable bits; writing ones to a disable register
// clears them. A source is pending when its level and its enable bit are both
// high. Each input transaction yields exactly one master-side transaction with
// the read data, the request line and the lowest-numbered pending source; a
// write takes effect before the request and active source are formed.
// A transaction passes from the input register into the result register, which
// drives m_tvalid. Throughput is one transaction per cycle while m_tready stays
// high, set by the single pass through the enable update and the 32-bit priority
// encoders. When the receiver stalls, the result register holds, the input
// register fills, and s_tready drops until m_tready returns.
// Reset clears all enables and both valid flags.
module banked_interrupt_controller #(
    parameter int SOURCE_COUNT = bic_pkg::SOURCE_COUNT_DEFAULT,
    parameter int BASIC_BITS   = SOURCE_COUNT - bic_pkg::BASIC_BASE,
    parameter int IN_TDATA_WIDTH = ((6 + 3 * bic_pkg::BANK_WIDTH + BASIC_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: command[2], reg_index[4], write_data[32],
    // sources_bank1[32], sources_bank2[32], sources_basic[BASIC_BITS], zero fill.
    input  logic [IN_TDATA_WIDTH-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: read_data[32], irq_request[1], active_source[7].
    output logic [bic_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);
    import bic_pkg::*;

    `include "banked_interrupt_controller_assert.svh"

    localparam int DATA_LSB  = 6;
    localparam int LV1_LSB   = DATA_LSB + BANK_WIDTH;
    localparam int LV2_LSB   = LV1_LSB + BANK_WIDTH;
    localparam int LVB_LSB   = LV2_LSB + BANK_WIDTH;

    // Input register.
    logic                  in_valid_reg;
    logic [1:0]            cmd_reg;
    logic [3:0]            idx_reg;
    word_t                 data_reg;
    word_t                 lv1_reg;
    word_t                 lv2_reg;
    logic [BASIC_BITS-1:0] lvb_reg;

    // Enable state.
    word_t                 en1_reg, en1_next;
    word_t                 en2_reg, en2_next;
    logic [BASIC_BITS-1:0] enb_reg, enb_next;

    // Result register.
    logic                  out_valid_reg;
    word_t                 rd_reg, rd_next;
    logic                  irq_reg, irq_next;
    logic [ACTIVE_WIDTH-1:0] act_reg, act_next;

    logic                  advance;
    logic                  out_free;
    word_t                 p1, p2;
    logic [BASIC_BITS-1:0] pb;
    word_t                 pb_word;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg  <= s_tdata[1:0];
            idx_reg  <= s_tdata[5:2];
            data_reg <= s_tdata[DATA_LSB +: BANK_WIDTH];
            lv1_reg  <= s_tdata[LV1_LSB +: BANK_WIDTH];
            lv2_reg  <= s_tdata[LV2_LSB +: BANK_WIDTH];
            lvb_reg  <= s_tdata[LVB_LSB +: BASIC_BITS];
        end
    end

    // Register read uses the enables as they stand before this transaction.
    always_comb begin
        rd_next = '0;
        if (cmd_reg == CMD_READ) begin
            case (idx_reg)
                REG_PEND_BASIC:              rd_next = BANK_WIDTH'(lvb_reg & enb_reg);
                REG_PEND_BANK1:              rd_next = lv1_reg & en1_reg;
                REG_PEND_BANK2:              rd_next = lv2_reg & en2_reg;
                REG_EN_BANK1, REG_DIS_BANK1: rd_next = en1_reg;
                REG_EN_BANK2, REG_DIS_BANK2: rd_next = en2_reg;
                REG_EN_BASIC, REG_DIS_BASIC: rd_next = BANK_WIDTH'(enb_reg);
                default:                     rd_next = '0;
            endcase
        end
    end

    always_comb begin
        en1_next = en1_reg;
        en2_next = en2_reg;
        enb_next = enb_reg;
        if (cmd_reg == CMD_WRITE) begin
            case (idx_reg)
                REG_EN_BANK1:  en1_next = en1_reg | data_reg;
                REG_EN_BANK2:  en2_next = en2_reg | data_reg;
                REG_EN_BASIC:  enb_next = enb_reg | data_reg[BASIC_BITS-1:0];
                REG_DIS_BANK1: en1_next = en1_reg & ~data_reg;
                REG_DIS_BANK2: en2_next = en2_reg & ~data_reg;
                REG_DIS_BASIC: enb_next = enb_reg & ~data_reg[BASIC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pending bits and priority: bank 1 first, then bank 2, then basic.
    always_comb begin
        p1       = lv1_reg & en1_next;
        p2       = lv2_reg & en2_next;
        pb       = lvb_reg & enb_next;
        pb_word  = BANK_WIDTH'(pb);
        irq_next = 1'b1;
        if (p1 != '0) begin
            act_next = {BANK_SEL_1, lowest_set(p1)};
        end else if (p2 != '0) begin
            act_next = {BANK_SEL_2, lowest_set(p2)};
        end else if (pb_word != '0) begin
            act_next = {BANK_SEL_BASIC, lowest_set(pb_word)};
        end else begin
            irq_next = 1'b0;
            act_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en1_reg       <= '0;
            en2_reg       <= '0;
            enb_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                en1_reg <= en1_next;
                en2_reg <= en2_next;
                enb_reg <= enb_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
            act_reg <= act_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {act_reg, irq_reg, rd_reg};

    `BIC_ASSERT_SAME(a_idle_active_zero, aclk, aresetn, m_tvalid && !irq_reg, act_reg == '0,
        "active source nonzero without a request")
    `BIC_ASSERT_SAME(a_active_in_range, aclk, aresetn, m_tvalid && irq_reg,
        act_reg < ACTIVE_WIDTH'(SOURCE_COUNT), "active source beyond the source count")
    `BIC_ASSERT_NEXT(a_enables_hold, aclk, aresetn, !advance,
        $stable(en1_reg) && $stable(en2_reg) && $stable(enb_reg),
        "enable state changed without a transaction moving to the output")
    `BIC_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, in_valid_reg && m_tvalid && !m_tready,
        !s_tready, "input accepted while both stages are full and stalled")

endmodule

FILE: tb/tb_banked_interrupt_controller.sv
// Self-checking testbench for the banked interrupt controller stream block.
module tb_banked_interrupt_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import bic_pkg::*;

    localparam int BASIC_W   = SOURCE_COUNT_DEFAULT - BASIC_BASE;
    localparam int IN_W      = ((6 + 3 * BANK_WIDTH + BASIC_W + 7) / 8) * 8;
    localparam int CYCLE_CAP = 200000;
    localparam int SETTLE    = 8;
    localparam int RANDOM_N  = 1100;
    // The command encoding that the block treats as a plain sample.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    // A register index that maps to no register at all.
    localparam logic [3:0] REG_UNMAPPED = 4'd15;

    typedef struct {
        logic [1:0]         cmd;
        logic [3:0]         idx;
        logic [31:0]        wdata;
        logic [31:0]        lv1;
        logic [31:0]        lv2;
        logic [BASIC_W-1:0] lvb;
        bit                 drain;
    } access_t;

    typedef struct {
        logic [31:0]             rd;
        logic                    irq;
        logic [ACTIVE_WIDTH-1:0] act;
    } irq_status_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_W-1:0]            s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;

    access_t     access_q[$];
    irq_status_t status_q[$];
    access_t     on_bus;
    irq_status_t want, got;

    logic [31:0]        en_bank1 = '0;
    logic [31:0]        en_bank2 = '0;
    logic [BASIC_W-1:0] en_basic = '0;

    int fail_cnt   = 0;
    int sent_cnt   = 0;
    int recv_cnt   = 0;
    int cycle_cnt  = 0;
    int directed_n = 0;

    banked_interrupt_controller u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    function automatic logic [4:0] first_one(input logic [31:0] v);
        for (int i = 0; i < 32; i++) begin
            if (v[i]) return 5'(i);
        end
        return '0;
    endfunction

    // Source levels and write data: mostly sparse so that the priority
    // encoder sees single bits and empty banks as often as dense words.
    function automatic logic [31:0] bit_pattern();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return 32'd1 << $urandom_range(31);
            3, 4:    return $urandom;
            8:       return '1;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Applies one accepted access to the enable copy and queues its status.
    task automatic apply_access(input access_t a);
        irq_status_t        s;
        logic [31:0]        p1, p2;
        logic [BASIC_W-1:0] pb;
        s = '{rd: '0, irq: 1'b0, act: '0};
        if (a.cmd == CMD_READ) begin
            case (a.idx)
                REG_PEND_BASIC:               s.rd = 32'(a.lvb & en_basic);
                REG_PEND_BANK1:               s.rd = a.lv1 & en_bank1;
                REG_PEND_BANK2:               s.rd = a.lv2 & en_bank2;
                REG_EN_BANK1, REG_DIS_BANK1:  s.rd = en_bank1;
                REG_EN_BANK2, REG_DIS_BANK2:  s.rd = en_bank2;
                REG_EN_BASIC, REG_DIS_BASIC:  s.rd = 32'(en_basic);
                default:                      s.rd = '0;
            endcase
        end else if (a.cmd == CMD_WRITE) begin
            case (a.idx)
                REG_EN_BANK1:  en_bank1 = en_bank1 | a.wdata;
                REG_EN_BANK2:  en_bank2 = en_bank2 | a.wdata;
                REG_EN_BASIC:  en_basic = en_basic | a.wdata[BASIC_W-1:0];
                REG_DIS_BANK1: en_bank1 = en_bank1 & ~a.wdata;
                REG_DIS_BANK2: en_bank2 = en_bank2 & ~a.wdata;
                REG_DIS_BASIC: en_basic = en_basic & ~a.wdata[BASIC_W-1:0];
                default: ;
            endcase
        end
        p1 = a.lv1 & en_bank1;
        p2 = a.lv2 & en_bank2;
        pb = a.lvb & en_basic;
        if (p1 != '0) begin
            s.irq = 1'b1;
            s.act = ACTIVE_WIDTH'(first_one(p1));
        end else if (p2 != '0) begin
            s.irq = 1'b1;
            s.act = ACTIVE_WIDTH'(BANK_WIDTH + first_one(p2));
        end else if (pb != '0) begin
            s.irq = 1'b1;
            s.act = ACTIVE_WIDTH'(BASIC_BASE + first_one(32'(pb)));
        end
        status_q.push_back(s);
    endtask

    task automatic add_access(input logic [1:0] cmd, input logic [3:0] idx,
                              input logic [31:0] wdata, input logic [31:0] lv1,
                              input logic [31:0] lv2, input logic [BASIC_W-1:0] lvb);
        access_t a;
        a = '{cmd: cmd, idx: idx, wdata: wdata, lv1: lv1, lv2: lv2, lvb: lvb, drain: 1'b0};
        access_q.push_back(a);
    endtask

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    // Sender: a new transaction goes out once the previous one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) apply_access(on_bus);
            if (!s_tvalid || s_tready) begin
                if (access_q.size() != 0
                        && !(access_q[0].drain && status_q.size() != 0)
                        && ((sent_cnt >= 300 && sent_cnt < 500)
                            || $urandom_range(99) >= 28)) begin
                    on_bus = access_q.pop_front();
                    s_tdata <= IN_W'({on_bus.lvb, on_bus.lv2, on_bus.lv1,
                                      on_bus.wdata, on_bus.idx, on_bus.cmd});
                    s_tvalid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction against the oldest status.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                recv_cnt <= recv_cnt + 1;
                got.rd  = m_tdata[31:0];
                got.irq = m_tdata[32];
                got.act = m_tdata[39:33];
                if (status_q.size() == 0) begin
                    note_failure($sformatf("unexpected result rd=%h irq=%0d act=%0d",
                                           got.rd, got.irq, got.act));
                end else begin
                    want = status_q.pop_front();
                    if (got.rd !== want.rd || got.irq !== want.irq || got.act !== want.act)
                        note_failure($sformatf(
                            "rd exp %h got %h, irq exp %0d got %0d, act exp %0d got %0d",
                            want.rd, got.rd, want.irq, got.irq, want.act, got.act));
                end
            end
            m_tready <= (recv_cnt >= 700 && recv_cnt < 900) || $urandom_range(99) >= 28;
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_CAP) @(negedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [1:0]  cmd;
        logic [3:0]  idx;
        logic [31:0] lv1;
        int          sel;

        // Nothing enabled yet, so every source high still gives no request.
        add_access(CMD_SAMPLE, REG_PEND_BASIC, '0, '1, '1, '1);
        add_access(CMD_WRITE, REG_EN_BANK1, '0, '1, '1, '1);
        add_access(CMD_WRITE, REG_EN_BANK1, '1, 32'h8000_0000, '0, '0);
        add_access(CMD_WRITE, REG_EN_BANK2, '1, '0, 32'h8000_0000, '0);
        add_access(CMD_WRITE, REG_EN_BASIC, '1, '0, '0, 8'h80);
        add_access(CMD_SAMPLE, REG_PEND_BASIC, '0, '0, '0, 8'h01);
        add_access(CMD_SAMPLE, REG_PEND_BASIC, '0, '1, '1, '1);
        add_access(CMD_READ, REG_EN_BANK1, '0, '0, '0, '0);
        add_access(CMD_READ, REG_DIS_BANK2, '0, '0, '0, '0);
        add_access(CMD_READ, REG_EN_BASIC, '0, '0, '0, '0);
        add_access(CMD_READ, REG_PEND_BASIC, '0, '0, '0, 8'hAA);
        add_access(CMD_READ, REG_PEND_BANK1, '0, 32'h0F0F_0F00, '0, '0);
        add_access(CMD_READ, REG_PEND_BANK2, '0, '0, 32'hF000_0000, '0);
        add_access(CMD_WRITE, REG_FIQ_CTRL, '1, '0, '0, '0);
        add_access(CMD_READ, REG_FIQ_CTRL, '0, '0, '0, '0);
        add_access(CMD_WRITE, REG_PEND_BANK1, '1, '0, '0, '0);
        add_access(CMD_WRITE, REG_UNMAPPED, '1, '0, '0, '0);
        add_access(CMD_READ, REG_UNMAPPED, '0, '1, '1, '1);
        add_access(CMD_SPARE, REG_EN_BANK1, '1, '0, 32'h0000_0100, '0);
        add_access(CMD_WRITE, REG_DIS_BANK1, '1, '1, '1, '1);
        add_access(CMD_WRITE, REG_DIS_BANK2, '1, '1, '1, '1);
        add_access(CMD_WRITE, REG_DIS_BASIC, '1, '1, '1, '1);
        add_access(CMD_READ, REG_DIS_BASIC, '0, '1, '1, '1);
        directed_n = access_q.size();

        for (int n = 0; n < RANDOM_N; n++) begin
            sel = $urandom_range(99);
            cmd = sel < 40 ? CMD_SAMPLE : sel < 65 ? CMD_READ : sel < 95 ? CMD_WRITE : CMD_SPARE;
            if (cmd == CMD_WRITE && $urandom_range(99) < 85)
                idx = 4'($urandom_range(REG_DIS_BASIC, REG_EN_BANK1));
            else
                idx = 4'($urandom_range(15));
            // An empty bank 1 lets the upper banks win the priority encoder.
            lv1 = $urandom_range(2) == 0 ? '0 : bit_pattern();
            add_access(cmd, idx, bit_pattern(), lv1, bit_pattern(),
                       BASIC_W'(bit_pattern()));
        end
        access_q[directed_n].drain = 1'b1;
        access_q[directed_n + 600].drain = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (access_q.size() != 0 || s_tvalid || status_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        if (fail_cnt == 0 && status_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bic_pkg.sv
hw/rtl/banked_interrupt_controller.sv
tb/tb_banked_interrupt_controller.sv
